// File: rtl/qpc_pkg.sv
package qpc_pkg;

   // Request commands
   localparam logic CMD_SAMPLE = 1'b0;
   localparam logic CMD_LOAD   = 1'b1;

   // Register indexes on the write port
   localparam int CSR_INDEX_W = 2;
   localparam logic [CSR_INDEX_W-1:0] REG_DIFFERENTIAL_MODE = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_SCALE_FACTOR      = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_INVERT_DIRECTION  = 2'd2;

   localparam int CSR_DATA_W = 21;
   localparam int SCALE_W    = 20;   // magnitude bits of a positive scale factor
   localparam logic signed [CSR_DATA_W-1:0] SCALE_ONE = 21'sd10000;

   localparam int POS_W = 32;
   localparam logic [POS_W-1:0] INT32_MAX = 32'h7FFF_FFFF;
   localparam logic [POS_W-1:0] INT32_MIN = 32'h8000_0000;
   localparam logic signed [63:0] INT32_MAX_64 = 64'sh0000_0000_7FFF_FFFF;
   localparam logic signed [63:0] INT32_MIN_64 = 64'shFFFF_FFFF_8000_0000;

   // product / 10000 saturates exactly when product >= 10000 * 2^31
   localparam logic [63:0] SAT_LIMIT = 64'd21474836480000;
   localparam int SAT_LIMIT_W = 45;

   // product / 10000 = (product >> 4) / 625; quotient by reciprocal 2^41 / 625
   localparam int DIV_SHIFT   = 4;
   localparam int X_W         = SAT_LIMIT_W - DIV_SHIFT;   // 41
   localparam int X_LO_W      = 21;
   localparam int RECIP_W     = 32;
   localparam int RECIP_SHIFT = 41;
   localparam logic [RECIP_W-1:0] RECIP = 32'd3518437208;
   localparam int DIVISOR_W   = 10;
   localparam logic [DIVISOR_W-1:0] DIVISOR = 10'd625;
   localparam int QUOT_W      = 32;

   typedef struct packed {
      logic                    differential_mode;
      logic                    invert_direction;
      logic signed [CSR_DATA_W-1:0] scale_factor;
   } cfg_type;

   // Values that ride along with a request through the scaling pipeline
   typedef struct packed {
      logic [POS_W-1:0] raw_position;
      logic             neg;
      logic             bypass;
      logic [POS_W-1:0] bypass_value;
   } side_type;

endpackage

// File: rtl/qpc_decoder.sv
module qpc_decoder #(
   parameter int COUNT_WIDTH = 32
) (
   input  logic                   clock,
   input  logic                   reset,
   input  qpc_pkg::cfg_type       cfg,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic                   req_command,
   input  logic                   req_line_a,
   input  logic                   req_line_b,
   input  logic                   req_line_a_neg,
   input  logic                   req_line_b_neg,
   input  logic signed [31:0]     req_load_value,
   output logic                   out_valid,
   input  logic                   out_stall,
   output qpc_pkg::side_type      out_side,
   output logic [COUNT_WIDTH-1:0] out_mag
);
   import qpc_pkg::*;

   localparam int W = COUNT_WIDTH;

   logic [W-1:0]        count_ff, count_in, count_next;
   logic                cur_a_ff, cur_a_in, cur_b_ff, cur_b_in;
   logic                out_valid_ff, out_valid_in;
   side_type            out_side_ff, out_side_in;
   logic [W-1:0]        out_mag_ff, out_mag_in;
   logic                accept, good, new_a, new_b, step_down, step_up;
   logic signed [W:0]   pos, pos_abs;
   logic signed [63:0]  pos64;

   assign req_stall = out_valid_ff && out_stall;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      good = !cfg.differential_mode ||
             ((req_line_a ^ req_line_a_neg) && (req_line_b ^ req_line_b_neg));
      new_a = good ? req_line_a : cur_a_ff;
      new_b = good ? req_line_b : cur_b_ff;
      step_down = new_b && !cur_a_ff && new_a;
      step_up   = new_b && cur_a_ff && !new_a;

      count_next = count_ff;
      cur_a_in   = cur_a_ff;
      cur_b_in   = cur_b_ff;
      if (req_command == CMD_LOAD) begin
         count_next = W'(req_load_value);
      end else begin
         cur_a_in = new_a;
         cur_b_in = new_b;
         if (step_down) begin
            count_next = count_ff - W'(1);
         end else if (step_up) begin
            count_next = count_ff + W'(1);
         end
      end
      count_in = accept ? count_next : count_ff;
      if (!accept) begin
         cur_a_in = cur_a_ff;
         cur_b_in = cur_b_ff;
      end

      pos = $signed({count_in[W-1], count_in});
      if (cfg.invert_direction) begin
         pos = -pos;
      end
      pos64   = 64'(pos);
      pos_abs = pos[W] ? -pos : pos;

      out_side_in.raw_position = pos64[POS_W-1:0];
      out_side_in.neg          = pos[W];
      out_side_in.bypass       = (cfg.scale_factor == SCALE_ONE) ||
                                 cfg.scale_factor[CSR_DATA_W-1] ||
                                 (cfg.scale_factor == '0);
      if (pos64 > INT32_MAX_64) begin
         out_side_in.bypass_value = INT32_MAX;
      end else if (pos64 < INT32_MIN_64) begin
         out_side_in.bypass_value = INT32_MIN;
      end else begin
         out_side_in.bypass_value = pos64[POS_W-1:0];
      end
      out_mag_in = pos_abs[W-1:0];

      // hold while the result is stalled, drop once taken
      out_valid_in = accept ? 1'b1 : (out_valid_ff && out_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         cur_a_ff     <= 1'b0;
         cur_b_ff     <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         cur_a_ff     <= cur_a_in;
         cur_b_ff     <= cur_b_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         out_side_ff <= out_side_in;
         out_mag_ff  <= out_mag_in;
      end
   end

   assign out_valid = out_valid_ff;
   assign out_side  = out_side_ff;
   assign out_mag   = out_mag_ff;

   a_sample_step: assert property (@(posedge clock) disable iff (reset)
      accept && req_command == CMD_SAMPLE |=>
         count_ff == $past(count_ff) || count_ff == $past(count_ff) + W'(1) ||
         count_ff == $past(count_ff) - W'(1))
      else $error("count moved by more than one step on a sample");

   a_load: assert property (@(posedge clock) disable iff (reset)
      accept && req_command == CMD_LOAD |=> count_ff == W'($past(req_load_value)))
      else $error("load did not set the count");

   a_diff_hold: assert property (@(posedge clock) disable iff (reset)
      accept && req_command == CMD_SAMPLE && cfg.differential_mode &&
      !((req_line_a ^ req_line_a_neg) && (req_line_b ^ req_line_b_neg)) |=>
         cur_a_ff == $past(cur_a_ff) && cur_b_ff == $past(cur_b_ff))
      else $error("bad differential sample changed the line levels");

endmodule

// File: rtl/qpc_scaler.sv
module qpc_scaler #(
   parameter int COUNT_WIDTH = 32
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic [qpc_pkg::SCALE_W-1:0] scale,
   input  logic                        in_valid,
   output logic                        in_stall,
   input  qpc_pkg::side_type           in_side,
   input  logic [COUNT_WIDTH-1:0]      in_mag,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic signed [31:0]          rsp_raw_position,
   output logic signed [31:0]          rsp_scaled_position
);
   import qpc_pkg::*;

   localparam int W      = COUNT_WIDTH;
   localparam int HALF   = (W + 1) / 2;
   localparam int HI_W   = W - HALF;
   localparam int PW     = W + SCALE_W;
   localparam int EXT_W  = (PW > SAT_LIMIT_W) ? PW : SAT_LIMIT_W;
   localparam int X_HI_W = X_W - X_LO_W;
   localparam int XR_W   = X_W + RECIP_W;
   localparam int QM_W   = QUOT_W + DIVISOR_W;
   localparam int NSTAGE = 7;

   logic [NSTAGE-1:0]          valid_ff, valid_in, ready;
   side_type                   side_ff [NSTAGE-1];

   logic [HALF+SCALE_W-1:0]    pp_lo_ff;
   logic [HI_W+SCALE_W-1:0]    pp_hi_ff;
   logic [PW-1:0]              prod;
   logic [EXT_W-1:0]           prod_ext;
   logic [X_W-1:0]             x1_ff, x2_ff, x3_ff, x4_ff;
   logic                       sat1_ff, sat2_ff, sat3_ff, sat4_ff, sat5_ff;
   logic [X_LO_W+RECIP_W-1:0]  xr_lo_ff;
   logic [X_HI_W+RECIP_W-1:0]  xr_hi_ff;
   logic [XR_W-1:0]            xr_sum;
   logic [QUOT_W-1:0]          q3_ff, q4_ff, q5_ff;
   logic [QM_W-1:0]            qm4_ff;
   logic [QM_W-1:0]            rem;
   logic                       ge5_ff;
   logic [QUOT_W-1:0]          quot;
   logic [POS_W-1:0]           scaled;
   logic [POS_W-1:0]           rsp_raw_ff, rsp_scaled_ff;

   // a stage advances when it is empty or the next one advances
   always_comb begin
      ready[NSTAGE-1] = !valid_ff[NSTAGE-1] || !rsp_stall;
      for (int k = NSTAGE - 2; k >= 0; k--) begin
         ready[k] = !valid_ff[k] || ready[k+1];
      end
      valid_in[0] = ready[0] ? in_valid : valid_ff[0];
      for (int k = 1; k < NSTAGE; k++) begin
         valid_in[k] = ready[k] ? valid_ff[k-1] : valid_ff[k];
      end
   end

   assign in_stall = !ready[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_comb begin
      prod     = (PW'(pp_hi_ff) << HALF) + PW'(pp_lo_ff);
      prod_ext = EXT_W'(prod);
      xr_sum   = (XR_W'(xr_hi_ff) << X_LO_W) + XR_W'(xr_lo_ff);
      rem      = QM_W'(x4_ff) - qm4_ff;
      quot     = q5_ff + QUOT_W'(ge5_ff);
      if (side_ff[5].bypass) begin
         scaled = side_ff[5].bypass_value;
      end else if (sat5_ff) begin
         scaled = side_ff[5].neg ? INT32_MIN : INT32_MAX;
      end else begin
         scaled = side_ff[5].neg ? -quot : quot;
      end
   end

   always_ff @(posedge clock) begin
      if (ready[0]) begin
         side_ff[0] <= in_side;
         pp_lo_ff   <= in_mag[HALF-1:0] * scale;
         pp_hi_ff   <= in_mag[W-1:HALF] * scale;
      end
      if (ready[1]) begin
         side_ff[1] <= side_ff[0];
         sat1_ff    <= prod_ext >= EXT_W'(SAT_LIMIT);
         x1_ff      <= prod_ext[SAT_LIMIT_W-1:DIV_SHIFT];
      end
      if (ready[2]) begin
         side_ff[2] <= side_ff[1];
         sat2_ff    <= sat1_ff;
         x2_ff      <= x1_ff;
         xr_lo_ff   <= x1_ff[X_LO_W-1:0] * RECIP;
         xr_hi_ff   <= x1_ff[X_W-1:X_LO_W] * RECIP;
      end
      if (ready[3]) begin
         side_ff[3] <= side_ff[2];
         sat3_ff    <= sat2_ff;
         x3_ff      <= x2_ff;
         q3_ff      <= xr_sum[XR_W-1:RECIP_SHIFT];
      end
      if (ready[4]) begin
         side_ff[4] <= side_ff[3];
         sat4_ff    <= sat3_ff;
         x4_ff      <= x3_ff;
         q4_ff      <= q3_ff;
         qm4_ff     <= q3_ff * DIVISOR;
      end
      if (ready[5]) begin
         side_ff[5] <= side_ff[4];
         sat5_ff    <= sat4_ff;
         q5_ff      <= q4_ff;
         // reciprocal estimate runs at most one low
         ge5_ff     <= rem >= QM_W'(DIVISOR);
      end
      if (ready[6]) begin
         rsp_raw_ff    <= side_ff[5].raw_position;
         rsp_scaled_ff <= scaled;
      end
   end

   assign rsp_valid           = valid_ff[NSTAGE-1];
   assign rsp_raw_position    = rsp_raw_ff;
   assign rsp_scaled_position = rsp_scaled_ff;

   a_estimate_close: assert property (@(posedge clock) disable iff (reset)
      valid_ff[4] && !side_ff[4].bypass && !sat4_ff |-> rem < QM_W'(2 * 625))
      else $error("quotient estimate off by more than one");

   a_quot_range: assert property (@(posedge clock) disable iff (reset)
      valid_ff[5] && !side_ff[5].bypass && !sat5_ff |-> !quot[QUOT_W-1])
      else $error("unsaturated quotient out of 31-bit range");

   a_stall_chain: assert property (@(posedge clock) disable iff (reset)
      !ready[0] |-> (&valid_ff) && rsp_stall)
      else $error("input stalled with a free stage in the pipeline");

endmodule

// File: rtl/quadrature_position_counter_unit.sv
// Quadrature position counter, x1 decoding on channel A.
// Request channel (req_valid / req_stall): one request per cycle while req_stall
// is low, either a sample of the A, B, /A, /B lines or a load of req_load_value
// into the count. Result channel (rsp_valid / rsp_stall): one result per request,
// in order, with the signed position and the position scaled by scale_factor / 10000
// (unscaled when scale_factor is zero or negative). Throughput is one request
// per cycle while rsp_stall is low, set by the scaling pipeline (decode
// register, two split multiply stages, sum/saturation check, reciprocal
// divide by 625 with one correction step, output register). The user must
// write configuration (csr_wr_en, csr_index, csr_wdata) only while no request
// is in flight; the block does not enforce this. Unknown indexes are ignored.
// Reset clears the count and line levels, empties the pipeline and restores
// differential_mode 0, scale_factor 10000, invert_direction 0.
// While rsp_stall is high the result holds; earlier stages keep filling and
// req_stall rises only once every stage holds a request.
module quadrature_position_counter_unit #(
   parameter int COUNT_WIDTH = 32
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_wr_en,
   input  logic [qpc_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [qpc_pkg::CSR_DATA_W-1:0]       csr_wdata,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic                                 req_command,
   input  logic                                 req_line_a,
   input  logic                                 req_line_b,
   input  logic                                 req_line_a_neg,
   input  logic                                 req_line_b_neg,
   input  logic signed [31:0]                   req_load_value,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic signed [31:0]                   rsp_raw_position,
   output logic signed [31:0]                   rsp_scaled_position
);
   import qpc_pkg::*;

   logic                          differential_mode_ff, differential_mode_in;
   logic signed [CSR_DATA_W-1:0]  scale_factor_ff, scale_factor_in;
   logic                          invert_direction_ff, invert_direction_in;
   cfg_type                       cfg;
   logic                          dec_valid, dec_stall;
   side_type                      dec_side;
   logic [COUNT_WIDTH-1:0]        dec_mag;

   always_comb begin
      differential_mode_in = differential_mode_ff;
      scale_factor_in      = scale_factor_ff;
      invert_direction_in  = invert_direction_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            REG_DIFFERENTIAL_MODE: differential_mode_in = csr_wdata[0];
            REG_SCALE_FACTOR:      scale_factor_in      = csr_wdata;
            REG_INVERT_DIRECTION:  invert_direction_in  = csr_wdata[0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         differential_mode_ff <= 1'b0;
         scale_factor_ff      <= SCALE_ONE;
         invert_direction_ff  <= 1'b0;
      end else begin
         differential_mode_ff <= differential_mode_in;
         scale_factor_ff      <= scale_factor_in;
         invert_direction_ff  <= invert_direction_in;
      end
   end

   assign cfg.differential_mode = differential_mode_ff;
   assign cfg.invert_direction  = invert_direction_ff;
   assign cfg.scale_factor      = scale_factor_ff;

   qpc_decoder #(
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_decoder (
      .clock          (clock),
      .reset          (reset),
      .cfg            (cfg),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_command    (req_command),
      .req_line_a     (req_line_a),
      .req_line_b     (req_line_b),
      .req_line_a_neg (req_line_a_neg),
      .req_line_b_neg (req_line_b_neg),
      .req_load_value (req_load_value),
      .out_valid      (dec_valid),
      .out_stall      (dec_stall),
      .out_side       (dec_side),
      .out_mag        (dec_mag)
   );

   qpc_scaler #(
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_scaler (
      .clock               (clock),
      .reset               (reset),
      .scale               (scale_factor_ff[SCALE_W-1:0]),
      .in_valid            (dec_valid),
      .in_stall            (dec_stall),
      .in_side             (dec_side),
      .in_mag              (dec_mag),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_raw_position    (rsp_raw_position),
      .rsp_scaled_position (rsp_scaled_position)
   );

endmodule
